/* design/vrh_pkg.sv */
`timescale 1ns / 1ps
package vrh_pkg;

  typedef enum logic [1:0] {
    CMD_COUNT   = 2'd0,
    CMD_PENALTY = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_VOXEL_SIZE = 3'd0;
  localparam logic [2:0] REG_MIN_X      = 3'd1;
  localparam logic [2:0] REG_MIN_Y      = 3'd2;
  localparam logic [2:0] REG_MIN_Z      = 3'd3;
  localparam logic [2:0] REG_STEPS_X    = 3'd4;
  localparam logic [2:0] REG_STEPS_Y    = 3'd5;
  localparam logic [2:0] REG_STEPS_Z    = 3'd6;

  localparam int CellBits = 15;
  localparam int StoreDepth = 32768;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                in_grid;
    logic [CellBits-1:0] cell_index;
    logic signed [31:0]  score;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [48:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

/* design/vrh_divider.sv */
`timescale 1ns / 1ps
module vrh_divider
  import vrh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [48:0] quotient
);

  logic [48:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [33:0] trial;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    trial = {1'b0, rem_r, quo_r[48]} - {2'b00, dvs_r};
    if (!trial[33]) begin
      rem_nxt = trial[31:0];
      quo_nxt = {quo_r[47:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[30:0], quo_r[48]};
      quo_nxt = {quo_r[47:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd48;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = quo_r;

endmodule

/* design/voxel_reach_histogram_unit.sv */
`timescale 1ns / 1ps
// Flow: each grid axis runs a serial divide on the shared divider, and a query inside the grid
// with a nonzero maximum score count adds the score divide on the same divider.
// A point found off the grid before the first axis divide skips every divide; a clear sweeps the penalty store.
// Flow control: one item at a time; the next input beat is taken after the result beat.
// Reset: synchronous active-low rst_n; a clearing pass then zeroes both stores.
module voxel_reach_histogram_unit
  import vrh_pkg::*;
#(
  parameter int AXES = 3,
  parameter int MAX_STEPS = 32,
  parameter int COUNT_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int StepW = $clog2(MAX_STEPS + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AXIS, S_WAIT, S_READ, S_RDATA, S_UPDATE, S_QDIV, S_QWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [30:0] vsize_r;
  logic signed [31:0] min_r [3];
  logic [5:0] steps_r [3];
  in_item_t item_r;
  logic [1:0] axis_r;
  logic [15:0] total_r;
  logic inside_r, clr_all_r, neg_r;
  logic [14:0] clr_r;
  logic [COUNT_BITS-1:0] max_r, rc_r;
  logic [31:0] pen_r;
  out_item_t res_r;
  logic [COUNT_BITS-1:0] reach_mem [StoreDepth];
  logic [31:0] pen_mem [StoreDepth];
  logic [COUNT_BITS-1:0] rc_q;
  logic [31:0] pen_q;

  div_req_t dreq;
  logic dbusy, ddone;
  logic [48:0] dquo;

  vrh_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .done(ddone),
                     .quotient(dquo));

  // per-axis offset and step clamp, plus the query score difference and dividend
  logic signed [32:0] diff;
  logic [5:0] st_raw;
  logic [StepW-1:0] st_cl;
  logic signed [31:0] coord_sel;
  logic signed [32:0] rdiff;
  logic [32:0] rabs;
  logic [48:0] qdiv;

  always_comb begin
    unique case (axis_r)
      2'd0: coord_sel = item_r.coord_x;
      2'd1: coord_sel = item_r.coord_y;
      default: coord_sel = item_r.coord_z;
    endcase
    diff = 33'(coord_sel) - 33'(min_r[axis_r]);
    st_raw = steps_r[axis_r];
    st_cl = (32'(st_raw) > MAX_STEPS) ? StepW'(MAX_STEPS) : StepW'(st_raw);
    rdiff = $signed({1'b0, 32'(rc_r)}) - $signed({1'b0, pen_r});
    rabs = rdiff[32] ? 33'(-rdiff) : 33'(rdiff);
    qdiv = {rabs, 16'd0};
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = 49'(diff[31:0]);
    dreq.divisor = 32'(vsize_r);
    if (state_r == S_AXIS && !diff[32] && st_cl != '0 && vsize_r != '0) dreq.start = 1'b1;
    if (state_r == S_QDIV) begin
      dreq.start = 1'b1;
      dreq.dividend = qdiv;
      dreq.divisor = 32'(max_r);
    end
  end

  logic [63:0] sq;
  logic [20:0] tnext;
  always_comb begin
    tnext = 21'(total_r) * 21'(st_cl) + 21'(dquo);
    sq = neg_r ? 64'(-$signed({15'd0, dquo})) : {15'd0, dquo};
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      pen_mem[clr_r] <= '0;
      if (clr_all_r) reach_mem[clr_r] <= '0;
    end else if (state_r == S_UPDATE && inside_r) begin
      if (item_r.cmd == CMD_COUNT && rc_r != CountMax) reach_mem[total_r[14:0]] <= rc_r + 1'b1;
      if (item_r.cmd == CMD_PENALTY)
        pen_mem[total_r[14:0]] <= ({1'b0, pen_r} + 33'(max_r) > 33'hFFFFFFFF) ? '1 :
                                  pen_r + 32'(max_r);
    end
    rc_q <= reach_mem[total_r[14:0]];
    pen_q <= pen_mem[total_r[14:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      clr_all_r <= 1'b1;
      max_r <= '0;
      vsize_r <= 31'd3277;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        steps_r[i] <= 6'd32;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_VOXEL_SIZE: vsize_r <= cfg_data[30:0];
          REG_MIN_X: min_r[0] <= cfg_data;
          REG_MIN_Y: min_r[1] <= cfg_data;
          REG_MIN_Z: min_r[2] <= cfg_data;
          REG_STEPS_X: steps_r[0] <= cfg_data[5:0];
          REG_STEPS_Y: steps_r[1] <= cfg_data[5:0];
          REG_STEPS_Z: steps_r[2] <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            clr_all_r <= 1'b0;
            state_r <= clr_all_r ? S_IDLE : S_OUT;
          end
        end
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          axis_r <= '0;
          total_r <= '0;
          inside_r <= 1'b1;
          res_r <= '0;
          if (in_data.cmd == CMD_CLEAR) begin
            clr_r <= '0;
            state_r <= S_CLEAR;
          end else state_r <= S_AXIS;
        end
        S_AXIS: begin
          if (dreq.start) state_r <= S_WAIT;
          else begin
            inside_r <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_WAIT: if (ddone) begin
          if (dquo >= 49'(st_cl) || tnext >= 21'(StoreDepth)) begin
            inside_r <= 1'b0;
            state_r <= S_READ;
          end else begin
            total_r <= tnext[15:0];
            if (32'(axis_r) == AXES - 1) state_r <= S_READ;
            else begin
              axis_r <= axis_r + 1'b1;
              state_r <= S_AXIS;
            end
          end
        end
        S_READ: begin
          if (!inside_r) total_r <= '0;
          state_r <= S_RDATA;
        end
        S_RDATA: begin
          rc_r <= rc_q;
          pen_r <= pen_q;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          res_r.in_grid <= inside_r;
          res_r.cell_index <= total_r[14:0];
          if (inside_r && item_r.cmd == CMD_COUNT) begin
            if (rc_r != CountMax && rc_r + 1'b1 > max_r) max_r <= rc_r + 1'b1;
            else if (rc_r > max_r) max_r <= rc_r;
          end
          if (inside_r && item_r.cmd == CMD_QUERY && max_r != '0) state_r <= S_QDIV;
          else state_r <= S_OUT;
        end
        S_QDIV: begin
          neg_r <= rdiff[32];
          state_r <= S_QWAIT;
        end
        S_QWAIT: if (ddone) begin
          if (!neg_r && dquo > 49'h7FFFFFFF) res_r.score <= 32'h7FFFFFFF;
          else if (neg_r && dquo > 49'h80000000) res_r.score <= 32'h80000000;
          else res_r.score <= sq[31:0];
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;
  assign cfg_ready = 1'b1;

  a_one_hot_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("output and input accepted together");
  a_grid_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_grid |-> out_data.cell_index == '0)
    else $error("index nonzero outside grid");
  a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> max_r >= $past(max_r)) else $error("max decreased");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !dbusy) else $error("divider started while busy");
endmodule
